// ===== rtl/vtae_pkg.sv =====
// Shared types and byte constants for the vector terminal address encoder.
package vtae_pkg;

   localparam int unsigned SLOTS = 6;

   // Command codes
   localparam logic [1:0] REQ_DRAW  = 2'd0;
   localparam logic [1:0] REQ_MOVE  = 2'd1;
   localparam logic [1:0] REQ_CLEAR = 2'd2;
   localparam logic [1:0] REQ_CLOSE = 2'd3;

   // Control characters
   localparam logic [6:0] CHAR_US  = 7'o037;
   localparam logic [6:0] CHAR_GS  = 7'o035;
   localparam logic [6:0] CHAR_ESC = 7'o033;
   localparam logic [6:0] CHAR_FF  = 7'o014;

   // Address byte tags
   localparam logic [6:0] TAG_HIGH  = 7'o040;
   localparam logic [6:0] TAG_LOW_Y = 7'o140;
   localparam logic [6:0] TAG_LOW_X = 7'o100;

   // Remembered-byte "unknown" marks
   localparam logic [5:0] UNKNOWN6 = 6'd63;
   localparam logic [4:0] UNKNOWN5 = 5'd31;

   // Slot positions within a queued item
   localparam int unsigned SLOT_GS = 0;
   localparam int unsigned SLOT_HY = 1;
   localparam int unsigned SLOT_EX = 2;
   localparam int unsigned SLOT_LY = 3;
   localparam int unsigned SLOT_HX = 4;
   localparam int unsigned SLOT_LX = 5;

   typedef logic [6:0] byte7_type;

   typedef struct packed {
      logic [SLOTS-1:0][6:0] bytes;
      logic [SLOTS-1:0]      mask;
   } entry_type;

endpackage

// ===== rtl/vector_terminal_address_encoder.sv =====
// Top level of the vector terminal address encoder: front end, item queue, back end.
//
// Usage
//   req_ channel: one command per item (draw, move, clear page, leave graph mode)
//     with a 12-bit x and y. req_ready is high whenever the item queue has room.
//   rsp_ channel: the bytes each command causes, one byte per item, in order;
//     rsp_last_byte marks the final byte of a command.
//   Path: a command's bytes pass through the item queue, then the back end's
//     work register, then the output register that drives rsp_.
//   Throughput: one byte per cycle while rsp_ready is high; a command has
//     1 to 5 bytes for draw, 2 to 6 for move, 2 for clear, 1 for leave. The
//     single output byte lane in the back end sets this figure; commands keep
//     entering while earlier ones are still being sent.
//   Reset: queue and output register empty, all remembered bytes unknown, so
//     the first address sends every byte.
//   Stall: when rsp_ready is low the output byte holds; the queue absorbs up to
//     QUEUE_DEPTH commands before req_ready drops.
module vector_terminal_address_encoder #(
   parameter int unsigned QUEUE_DEPTH = 2 // range 2 to 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_type,
   input  logic [11:0] req_x_coord,
   input  logic [11:0] req_y_coord,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [6:0]  rsp_out_byte,
   output logic        rsp_last_byte
);

   vtae_pkg::entry_type push_entry;
   vtae_pkg::entry_type head_entry;
   logic                push;
   logic                full;
   logic                pop;
   logic                head_valid;

   // an item is taken whenever the queue has a free slot
   assign req_ready = !full;
   assign push      = req_valid && req_ready;

   vtae_front u_front (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .req_type    (req_type),
      .req_x_coord (req_x_coord),
      .req_y_coord (req_y_coord),
      .entry       (push_entry)
   );

   vtae_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_entry (head_entry)
   );

   vtae_back u_back (
      .clock         (clock),
      .reset         (reset),
      .head_valid    (head_valid),
      .head_entry    (head_entry),
      .pop           (pop),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_out_byte  (rsp_out_byte),
      .rsp_last_byte (rsp_last_byte)
   );

endmodule

// ===== rtl/vtae_front.sv =====
// Front end: classifies commands, tracks remembered bytes, builds the byte list of each item.
module vtae_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  logic [1:0]          req_type,
   input  logic [11:0]         req_x_coord,
   input  logic [11:0]         req_y_coord,
   output vtae_pkg::entry_type entry
);

   logic [5:0] sent_hy_ff, sent_hy_in;
   logic [5:0] sent_hx_ff, sent_hx_in;
   logic [5:0] sent_ly_ff, sent_ly_in;
   logic [4:0] sent_ex_ff, sent_ex_in;

   logic [4:0] hy, hx, ly, lx;
   logic [3:0] ex;
   logic       hx_chg, ex_chg, ly_chg;

   assign hy = req_y_coord[11:7];
   assign hx = req_x_coord[11:7];
   assign ly = req_y_coord[6:2];
   assign lx = req_x_coord[6:2];
   assign ex = {req_y_coord[1:0], req_x_coord[1:0]};

   assign hx_chg = {1'b0, hx} != sent_hx_ff;
   assign ex_chg = {1'b0, ex} != sent_ex_ff;
   assign ly_chg = {1'b0, ly} != sent_ly_ff;

   always_comb begin
      entry.bytes = '0;
      entry.mask  = '0;
      sent_hy_in  = sent_hy_ff;
      sent_hx_in  = sent_hx_ff;
      sent_ly_in  = sent_ly_ff;
      sent_ex_in  = sent_ex_ff;
      case (req_type)
         vtae_pkg::REQ_DRAW, vtae_pkg::REQ_MOVE: begin
            entry.bytes[vtae_pkg::SLOT_GS] = vtae_pkg::CHAR_GS;
            entry.bytes[vtae_pkg::SLOT_HY] = vtae_pkg::TAG_HIGH  | {2'b00, hy};
            entry.bytes[vtae_pkg::SLOT_EX] = vtae_pkg::TAG_LOW_Y | {3'b000, ex};
            entry.bytes[vtae_pkg::SLOT_LY] = vtae_pkg::TAG_LOW_Y | {2'b00, ly};
            entry.bytes[vtae_pkg::SLOT_HX] = vtae_pkg::TAG_HIGH  | {2'b00, hx};
            entry.bytes[vtae_pkg::SLOT_LX] = vtae_pkg::TAG_LOW_X | {2'b00, lx};
            entry.mask[vtae_pkg::SLOT_GS]  = (req_type == vtae_pkg::REQ_MOVE);
            entry.mask[vtae_pkg::SLOT_HY]  = {1'b0, hy} != sent_hy_ff;
            entry.mask[vtae_pkg::SLOT_EX]  = ex_chg;
            // low-y goes out whenever anything it depends on has moved
            entry.mask[vtae_pkg::SLOT_LY]  = hx_chg | ex_chg | ly_chg;
            entry.mask[vtae_pkg::SLOT_HX]  = hx_chg;
            entry.mask[vtae_pkg::SLOT_LX]  = 1'b1;
            sent_hy_in = {1'b0, hy};
            sent_hx_in = {1'b0, hx};
            sent_ly_in = {1'b0, ly};
            sent_ex_in = {1'b0, ex};
         end
         vtae_pkg::REQ_CLEAR: begin
            entry.bytes[0] = vtae_pkg::CHAR_ESC;
            entry.bytes[1] = vtae_pkg::CHAR_FF;
            entry.mask     = vtae_pkg::SLOTS'(2'b11);
            sent_hy_in = vtae_pkg::UNKNOWN6;
            sent_hx_in = vtae_pkg::UNKNOWN6;
            sent_ly_in = vtae_pkg::UNKNOWN6;
            sent_ex_in = vtae_pkg::UNKNOWN5;
         end
         default: begin
            entry.bytes[0] = vtae_pkg::CHAR_US;
            entry.mask     = vtae_pkg::SLOTS'(1'b1);
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sent_hy_ff <= vtae_pkg::UNKNOWN6;
         sent_hx_ff <= vtae_pkg::UNKNOWN6;
         sent_ly_ff <= vtae_pkg::UNKNOWN6;
         sent_ex_ff <= vtae_pkg::UNKNOWN5;
      end else if (push) begin
         sent_hy_ff <= sent_hy_in;
         sent_hx_ff <= sent_hx_in;
         sent_ly_ff <= sent_ly_in;
         sent_ex_ff <= sent_ex_in;
      end
   end

endmodule

// ===== rtl/vtae_queue.sv =====
// Short FIFO of byte lists between front and back.
module vtae_queue #(
   parameter int unsigned DEPTH = 2
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  vtae_pkg::entry_type push_entry,
   output logic                full,
   input  logic                pop,
   output logic                head_valid,
   output vtae_pkg::entry_type head_entry
);

   localparam int unsigned PW = $clog2(DEPTH);
   localparam int unsigned CW = $clog2(DEPTH + 1);

   vtae_pkg::entry_type store_ff [DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;

   assign full       = count_ff == CW'(DEPTH);
   assign head_valid = count_ff != '0;
   assign head_entry = store_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         store_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

// ===== rtl/vtae_back.sv =====
// Back end: sends queued bytes one per cycle, unless rsp_ready stalls, via an output register.
module vtae_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                head_valid,
   input  vtae_pkg::entry_type head_entry,
   output logic                pop,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [6:0]          rsp_out_byte,
   output logic                rsp_last_byte
);

   logic                work_valid_ff, work_valid_in;
   vtae_pkg::entry_type work_ff, work_in;
   logic                out_valid_ff, out_valid_in;
   logic [6:0]          out_byte_ff, out_byte_in;
   logic                out_last_ff, out_last_in;

   logic                      advance;
   logic [2:0]                sel;
   logic [vtae_pkg::SLOTS-1:0] mask_next;
   logic                      finishing;

   assign advance = !out_valid_ff || rsp_ready;

   // lowest pending slot goes next
   always_comb begin
      sel = '0;
      for (int i = vtae_pkg::SLOTS - 1; i >= 0; i--) begin
         if (work_ff.mask[i]) begin
            sel = 3'(i);
         end
      end
   end

   assign mask_next = work_ff.mask & (work_ff.mask - vtae_pkg::SLOTS'(1));
   assign finishing = work_valid_ff && advance && (mask_next == '0);
   assign pop       = head_valid && (!work_valid_ff || finishing);

   always_comb begin
      work_valid_in = work_valid_ff;
      work_in       = work_ff;
      out_valid_in  = out_valid_ff;
      out_byte_in   = out_byte_ff;
      out_last_in   = out_last_ff;
      if (advance) begin
         out_valid_in = work_valid_ff;
         out_byte_in  = work_ff.bytes[sel];
         out_last_in  = mask_next == '0;
         if (work_valid_ff) begin
            work_in.mask = mask_next;
         end
      end
      if (finishing) begin
         work_valid_in = 1'b0;
      end
      if (pop) begin
         work_valid_in = 1'b1;
         work_in       = head_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         work_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         work_valid_ff <= work_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      work_ff     <= work_in;
      out_byte_ff <= out_byte_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_out_byte  = out_byte_ff;
   assign rsp_last_byte = out_last_ff;

endmodule

// ===== tb/vector_terminal_address_encoder_tb.sv =====
// Self-checking testbench for the vector terminal address encoder.
module vector_terminal_address_encoder_tb;
   timeunit 1ns;
   timeprecision 1ps;

   // One expected byte on the rsp_ channel
   typedef struct {
      vtae_pkg::byte7_type value;
      logic                last;
   } term_byte_type;

   // Tracks what the terminal has been told and what bytes must come back.
   // Remembered bytes mirror the block's own suppression state.
   class terminal_byte_tracker;
      term_byte_type       pending_bytes[$];
      logic [5:0]          known_high_y;
      logic [5:0]          known_high_x;
      logic [5:0]          known_low_y;
      logic [4:0]          known_extra;
      int unsigned         fault_count;
      int unsigned         checked_count;
      vtae_pkg::byte7_type burst[vtae_pkg::SLOTS];
      int unsigned         burst_len;

      function new();
         fault_count   = 0;
         checked_count = 0;
         forget();
      endfunction

      function void forget();
         known_high_y = vtae_pkg::UNKNOWN6;
         known_high_x = vtae_pkg::UNKNOWN6;
         known_low_y  = vtae_pkg::UNKNOWN6;
         known_extra  = vtae_pkg::UNKNOWN5;
      endfunction

      function void add(vtae_pkg::byte7_type b);
         burst[burst_len] = b;
         burst_len++;
      endfunction

      // Address bytes for one point, skipping those the terminal already holds
      function void encode_point(logic [11:0] x, logic [11:0] y);
         logic [4:0] hx;
         logic [4:0] hy;
         logic [4:0] lx;
         logic [4:0] ly;
         logic [3:0] ex;
         hx = x[11:7];
         hy = y[11:7];
         lx = x[6:2];
         ly = y[6:2];
         ex = {y[1:0], x[1:0]};
         if ({1'b0, hy} != known_high_y) begin
            add(vtae_pkg::TAG_HIGH | {2'b00, hy});
            known_high_y = {1'b0, hy};
         end
         if ({1'b0, hx} != known_high_x) begin
            if ({1'b0, ex} != known_extra) begin
               add(vtae_pkg::TAG_LOW_Y | {3'b000, ex});
               known_extra = {1'b0, ex};
            end
            add(vtae_pkg::TAG_LOW_Y | {2'b00, ly});
            add(vtae_pkg::TAG_HIGH | {2'b00, hx});
            known_high_x = {1'b0, hx};
            known_low_y  = {1'b0, ly};
         end else if ({1'b0, ex} != known_extra) begin
            add(vtae_pkg::TAG_LOW_Y | {3'b000, ex});
            add(vtae_pkg::TAG_LOW_Y | {2'b00, ly});
            known_extra = {1'b0, ex};
            known_low_y = {1'b0, ly};
         end else if ({1'b0, ly} != known_low_y) begin
            add(vtae_pkg::TAG_LOW_Y | {2'b00, ly});
            known_low_y = {1'b0, ly};
         end
         add(vtae_pkg::TAG_LOW_X | {2'b00, lx});
      endfunction

      // Called for every accepted command
      function void note_command(logic [1:0] kind, logic [11:0] x, logic [11:0] y);
         term_byte_type e;
         burst_len = 0;
         case (kind)
            vtae_pkg::REQ_DRAW: encode_point(x, y);
            vtae_pkg::REQ_MOVE: begin
               add(vtae_pkg::CHAR_GS);
               encode_point(x, y);
            end
            vtae_pkg::REQ_CLEAR: begin
               add(vtae_pkg::CHAR_ESC);
               add(vtae_pkg::CHAR_FF);
               forget();
            end
            default: add(vtae_pkg::CHAR_US);
         endcase
         for (int unsigned i = 0; i < burst_len; i++) begin
            e.value = burst[i];
            e.last  = (i == burst_len - 1);
            pending_bytes.push_back(e);
         end
      endfunction

      function void note_fault(string msg);
         fault_count++;
         if (fault_count <= 10)
            $display("[%0t] mismatch: %s", $realtime, msg);
      endfunction

      // Called for every accepted byte
      function void check_byte(vtae_pkg::byte7_type got_byte, logic got_last);
         term_byte_type want;
         checked_count++;
         if (pending_bytes.size() == 0) begin
            note_fault($sformatf("byte %03o last %b with nothing pending",
                                 got_byte, got_last));
            return;
         end
         want = pending_bytes.pop_front();
         if (want.value !== got_byte || want.last !== got_last)
            note_fault($sformatf("expected byte %03o last %b, got byte %03o last %b",
                                 want.value, want.last, got_byte, got_last));
      endfunction
   endclass

   localparam int unsigned WATCHDOG_LIMIT = 2000;
   localparam int unsigned HOLD_CYCLES    = 150;
   localparam int unsigned PHASE_ITEMS    = 85;

   logic        clock;
   logic        reset       = 1'b1;
   logic        req_valid   = 1'b0;
   logic        req_ready;
   logic [1:0]  req_type    = vtae_pkg::REQ_DRAW;
   logic [11:0] req_x_coord = '0;
   logic [11:0] req_y_coord = '0;
   logic        rsp_valid;
   logic        rsp_ready   = 1'b0;
   logic [6:0]  rsp_out_byte;
   logic        rsp_last_byte;

   terminal_byte_tracker tracker = new();

   int unsigned send_idle_pct = 0;
   int unsigned recv_idle_pct = 0;
   int unsigned hold_asked    = 0;   // bumped by the sender
   int unsigned hold_served   = 0;   // caught up by the receiver
   int unsigned idle_cycles   = 0;
   int unsigned kind_count[4] = '{0, 0, 0, 0};
   logic [11:0] last_x = '0;
   logic [11:0] last_y = '0;

   vector_terminal_address_encoder u_top (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_type      (req_type),
      .req_x_coord   (req_x_coord),
      .req_y_coord   (req_y_coord),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_out_byte  (rsp_out_byte),
      .rsp_last_byte (rsp_last_byte)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Receiver: random back-pressure, plus a long hold-off on request so the
   // queue fills and req_ready drops while the sender keeps offering.
   initial begin
      int unsigned hold_left;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (hold_left > 0) begin
            rsp_ready <= 1'b0;
            hold_left--;
         end else if (hold_served != hold_asked) begin
            hold_served = hold_asked;
            hold_left   = HOLD_CYCLES - 1;
            rsp_ready  <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   // Outputs are looked at mid-cycle, where everything has settled; a handshake
   // seen here completes at the following rising edge.
   always @(negedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready)
            tracker.check_byte(rsp_out_byte, rsp_last_byte);
         if ((rsp_valid && rsp_ready) || (req_valid && req_ready))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
   end

   // Watchdog: too long without any item moving on either channel
   initial begin
      while (idle_cycles < WATCHDOG_LIMIT)
         @(negedge clock);
      $display("[%0t] watchdog: no item moved for %0d cycles", $realtime, WATCHDOG_LIMIT);
      $display("vector_terminal_address_encoder_tb: errors");
      $finish;
   end

   // Offer one command; entered and left at a rising edge. Random gaps first,
   // then valid stays up with the payload fixed until the item is taken.
   task automatic send_command(input logic [1:0] kind, input logic [11:0] x,
                               input logic [11:0] y);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_type    <= kind;
      req_x_coord <= x;
      req_y_coord <= y;
      do @(negedge clock); while (!req_ready);
      @(posedge clock);
      tracker.note_command(kind, x, y);
      kind_count[kind]++;
      last_x = x;
      last_y = y;
   endtask

   // Sender stops until every expected byte is back
   task automatic wait_for_drain();
      req_valid <= 1'b0;
      while (tracker.pending_bytes.size() != 0)
         @(posedge clock);
   endtask

   // Coordinates near the previous one most of the time, so that suppression
   // of repeated bytes gets exercised, with full-range values mixed in.
   function automatic logic [11:0] pick_coord(input logic [11:0] prev);
      logic [11:0] v;
      case ($urandom_range(9))
         0, 1, 2: v = 12'($urandom_range(4095));
         3:       v = ($urandom_range(1) != 0) ? 12'hfff : 12'h000;
         4, 5, 6: v = prev ^ 12'($urandom_range(127));
         7:       v = prev;
         default: v = prev ^ (12'd1 << $urandom_range(11));
      endcase
      return v;
   endfunction

   initial begin
      logic [1:0]  kind;
      logic [11:0] x;
      logic [11:0] y;
      int unsigned roll;

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed commands, no idling
      send_command(vtae_pkg::REQ_CLOSE, 12'h000, 12'h000);    // leave before any address
      send_command(vtae_pkg::REQ_DRAW,  12'h000, 12'h000);    // all unknown: full address
      send_command(vtae_pkg::REQ_DRAW,  12'h000, 12'h000);    // repeat: low-x only
      send_command(vtae_pkg::REQ_DRAW,  12'hfff, 12'hfff);
      send_command(vtae_pkg::REQ_MOVE,  12'hfff, 12'hfff);    // GS then low-x
      send_command(vtae_pkg::REQ_MOVE,  12'h000, 12'hfff);
      send_command(vtae_pkg::REQ_DRAW,  12'h001, 12'hfff);    // extra alone changes
      send_command(vtae_pkg::REQ_DRAW,  12'h001, 12'hffb);    // low-y alone changes
      send_command(vtae_pkg::REQ_DRAW,  12'h081, 12'hffb);    // high-x changes, extra held
      send_command(vtae_pkg::REQ_DRAW,  12'h002, 12'hffb);    // high-x and extra change
      send_command(vtae_pkg::REQ_DRAW,  12'h002, 12'hf7b);    // high-y alone changes
      send_command(vtae_pkg::REQ_CLEAR, 12'hfff, 12'hfff);    // coordinates ignored
      send_command(vtae_pkg::REQ_DRAW,  12'h002, 12'hf7b);    // forgotten: full address
      send_command(vtae_pkg::REQ_CLEAR, 12'haaa, 12'h555);
      send_command(vtae_pkg::REQ_MOVE,  12'haaa, 12'h555);    // six bytes
      send_command(vtae_pkg::REQ_DRAW,  12'h555, 12'haaa);
      send_command(vtae_pkg::REQ_DRAW,  12'haaa, 12'h555);
      send_command(vtae_pkg::REQ_CLOSE, 12'hfff, 12'hfff);    // state kept across leave
      send_command(vtae_pkg::REQ_DRAW,  12'haaa, 12'h555);
      send_command(vtae_pkg::REQ_CLOSE, 12'h555, 12'haaa);
      send_command(vtae_pkg::REQ_MOVE,  12'hfff, 12'h000);
      wait_for_drain();

      // Random phases: sender/receiver idling 31/63, then 63/31, then none
      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin send_idle_pct = 31; recv_idle_pct = 63; end
            1: begin send_idle_pct = 63; recv_idle_pct = 31; end
            default: begin send_idle_pct = 0; recv_idle_pct = 0; end
         endcase
         for (int unsigned i = 0; i < PHASE_ITEMS; i++) begin
            if (phase != 1 && i == PHASE_ITEMS / 2)
               hold_asked++;
            roll = $urandom_range(99);
            if (roll < 50)
               kind = vtae_pkg::REQ_DRAW;
            else if (roll < 75)
               kind = vtae_pkg::REQ_MOVE;
            else if (roll < 85)
               kind = vtae_pkg::REQ_CLEAR;
            else
               kind = vtae_pkg::REQ_CLOSE;
            x = pick_coord(last_x);
            y = pick_coord(last_y);
            send_command(kind, x, y);
         end
         wait_for_drain();
      end

      // Let any stray byte show before closing
      repeat (20) @(posedge clock);
      if (tracker.pending_bytes.size() != 0)
         tracker.note_fault($sformatf("%0d bytes never arrived",
                                      tracker.pending_bytes.size()));

      $display("commands: %0d draw, %0d move, %0d clear, %0d leave; %0d bytes checked",
               kind_count[vtae_pkg::REQ_DRAW], kind_count[vtae_pkg::REQ_MOVE],
               kind_count[vtae_pkg::REQ_CLEAR], kind_count[vtae_pkg::REQ_CLOSE],
               tracker.checked_count);
      $display("idling mixes 31/63, 63/31 and none, long output hold-offs included; %0d faults",
               tracker.fault_count);
      if (tracker.fault_count == 0)
         $display("vector_terminal_address_encoder_tb: clean");
      else
         $display("vector_terminal_address_encoder_tb: errors");
      $finish;
   end

endmodule

// ===== vector_terminal_address_encoder.f =====
rtl/vtae_pkg.sv
rtl/vtae_front.sv
rtl/vtae_queue.sv
rtl/vtae_back.sv
rtl/vector_terminal_address_encoder.sv
tb/vector_terminal_address_encoder_tb.sv
